>>> design/plsc_pkg.sv
// package: types and constants for the proximity lid servo controller
package plsc_pkg;

  localparam int ECHO_W  = 15;
  localparam int HOLD_W  = 16;
  localparam int STEP_W  = 8;
  localparam int ANGLE_W = 8;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [1:0] {
    LID_CLOSED  = 2'd0,
    LID_OPENING = 2'd1,
    LID_OPEN    = 2'd2,
    LID_CLOSING = 2'd3
  } lid_state_t;

  localparam logic [CFG_IDX_W-1:0] REG_NEAR_ECHO    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_TICKS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_ANGLE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSED_ANGLE = 3'd4;

  localparam logic [ECHO_W-1:0]  NEAR_ECHO_RST    = 15'd1166;
  localparam logic [HOLD_W-1:0]  HOLD_TICKS_RST   = 16'd3000;
  localparam logic [STEP_W-1:0]  STEP_TICKS_RST   = 8'd15;
  localparam logic [ANGLE_W-1:0] OPEN_ANGLE_RST   = 8'd90;
  localparam logic [ANGLE_W-1:0] CLOSED_ANGLE_RST = 8'd0;

endpackage

>>> design/proximity_lid_servo_controller_core.sv
// top level: proximity triggered lid controller with stepped servo
//
// Each input request is one millisecond tick, optionally carrying a fresh
// ultrasonic echo time (in_sample_valid). A held echo that is nonzero and at
// or below near_echo_us means a hand is present. The lid walks through
// closed, opening, open and closing; the servo angle moves one degree per
// step interval while opening or closing.
// Channels: input and result both use valid/stall; a request moves on a
// rising edge with valid high and stall low. Configuration is a plain write
// port (cfg_wr_en, cfg_index, cfg_data) that the user writes only while
// the block is idle; the block does not check this. Results are registered.
// Throughput: one tick per cycle; all state updates in one pass through
// the comparators and the angle incrementer into the state registers.
// When the receiver stalls, the result register holds and in_stall rises,
// so no further tick is taken until the result leaves.
// Reset (rst_n low, synchronous) loads the default register values, closes
// the lid at the closed angle, clears the held echo and the hand timer and
// saturates the step timer.
module proximity_lid_servo_controller_core #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [plsc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [plsc_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_sample_valid,
  input  logic [plsc_pkg::ECHO_W-1:0]    in_echo_us,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     out_lid_state,
  output logic [plsc_pkg::ANGLE_W-1:0]   out_servo_angle,
  output logic                           out_angle_changed,
  output logic                           out_hand_seen
);
  import plsc_pkg::*;

  localparam int CMP_W = (TIMER_WIDTH > HOLD_W) ? TIMER_WIDTH : HOLD_W;

  logic [ECHO_W-1:0]  near_echo_r;
  logic [HOLD_W-1:0]  hold_ticks_r;
  logic [STEP_W-1:0]  step_ticks_r;
  logic [ANGLE_W-1:0] open_angle_r;
  logic [ANGLE_W-1:0] closed_angle_r;

  lid_state_t             mode_r, mode_nxt;
  logic [ANGLE_W-1:0]     angle_r, angle_nxt;
  logic [ECHO_W-1:0]      held_echo_r, held_echo_nxt;
  logic [TIMER_WIDTH-1:0] since_step_r, since_step_nxt;
  logic [TIMER_WIDTH-1:0] since_hand_r, since_hand_nxt;
  logic [TIMER_WIDTH-1:0] step_inc, hand_inc;

  logic                   out_valid_r, out_valid_nxt;
  logic [1:0]             out_state_r;
  logic [ANGLE_W-1:0]     out_angle_r;
  logic                   out_changed_r;
  logic                   out_hand_r;

  logic               in_accept;
  logic               hand;
  logic               step_due;
  logic               hold_due;
  logic               do_step;
  logic               at_goal;
  logic               moved;
  logic [ANGLE_W-1:0] goal;
  logic [ANGLE_W-1:0] angle_step;

  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_echo_r    <= NEAR_ECHO_RST;
      hold_ticks_r   <= HOLD_TICKS_RST;
      step_ticks_r   <= STEP_TICKS_RST;
      open_angle_r   <= OPEN_ANGLE_RST;
      closed_angle_r <= CLOSED_ANGLE_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_NEAR_ECHO:    near_echo_r    <= cfg_data[ECHO_W-1:0];
        REG_HOLD_TICKS:   hold_ticks_r   <= cfg_data[HOLD_W-1:0];
        REG_STEP_TICKS:   step_ticks_r   <= cfg_data[STEP_W-1:0];
        REG_OPEN_ANGLE:   open_angle_r   <= cfg_data[ANGLE_W-1:0];
        REG_CLOSED_ANGLE: closed_angle_r <= cfg_data[ANGLE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // echo hold, timers and step decision
  always_comb begin
    held_echo_nxt = in_sample_valid ? in_echo_us : held_echo_r;
    hand = (held_echo_nxt != '0) && (held_echo_nxt <= near_echo_r);
    step_inc = (since_step_r == '1) ? since_step_r : since_step_r + TIMER_WIDTH'(1);
    hand_inc = (since_hand_r == '1) ? since_hand_r : since_hand_r + TIMER_WIDTH'(1);
    step_due = CMP_W'(step_inc) >= CMP_W'(step_ticks_r);
    hold_due = CMP_W'(hand_inc) >= CMP_W'(hold_ticks_r);
    goal = (mode_r == LID_OPENING) ? open_angle_r : closed_angle_r;
    do_step = step_due &&
              ((mode_r == LID_OPENING) || ((mode_r == LID_CLOSING) && !hand));
    if (angle_r < goal) begin
      angle_step = angle_r + ANGLE_W'(1);
    end else if (angle_r > goal) begin
      angle_step = angle_r - ANGLE_W'(1);
    end else begin
      angle_step = angle_r;
    end
    at_goal   = angle_step == goal;
    moved     = do_step && (angle_r != goal);
    angle_nxt = do_step ? angle_step : angle_r;
    since_step_nxt = do_step ? '0 : step_inc;
    if (((mode_r == LID_OPENING) && do_step && at_goal) ||
        ((mode_r == LID_OPEN) && hand)) begin
      since_hand_nxt = '0;
    end else begin
      since_hand_nxt = hand_inc;
    end
  end

  // lid next state
  always_comb begin
    mode_nxt = mode_r;
    case (mode_r)
      LID_CLOSED: begin
        if (hand) mode_nxt = LID_OPENING;
      end
      LID_OPENING: begin
        if (do_step && at_goal) mode_nxt = LID_OPEN;
      end
      LID_OPEN: begin
        if (!hand && hold_due) mode_nxt = LID_CLOSING;
      end
      LID_CLOSING: begin
        if (hand) begin
          mode_nxt = LID_OPENING;
        end else if (do_step && at_goal) begin
          mode_nxt = LID_CLOSED;
        end
      end
      default: mode_nxt = LID_CLOSED;
    endcase
  end

  always_comb begin
    out_valid_nxt = in_accept | (out_valid_r & out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= LID_CLOSED;
      angle_r      <= CLOSED_ANGLE_RST;
      held_echo_r  <= '0;
      since_step_r <= '1;
      since_hand_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_accept) begin
        mode_r       <= mode_nxt;
        angle_r      <= angle_nxt;
        held_echo_r  <= held_echo_nxt;
        since_step_r <= since_step_nxt;
        since_hand_r <= since_hand_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_state_r   <= mode_nxt;
      out_angle_r   <= angle_nxt;
      out_changed_r <= moved;
      out_hand_r    <= hand;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_lid_state     = out_state_r;
  assign out_servo_angle   = out_angle_r;
  assign out_angle_changed = out_changed_r;
  assign out_hand_seen     = out_hand_r;

  a_angle_holds_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_accept |=> $stable(angle_r))
    else $error("servo angle changed without a request");

  a_step_clears_timer: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && do_step |=> since_step_r == '0)
    else $error("step timer not cleared after a step");

  a_hand_clears_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && (mode_r == LID_OPEN) && hand |=> since_hand_r == '0)
    else $error("hold timer not cleared by a hand while open");

  a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (out_servo_angle == angle_r) && (out_lid_state == mode_r))
    else $error("result does not match lid state");

endmodule

>>> dv/tb_proximity_lid_servo_controller_core.sv
// testbench for the proximity lid servo controller: random echo ticks checked against a lid model
module tb_proximity_lid_servo_controller_core;
  import plsc_pkg::*;

  localparam int TMR_W          = 16;
  localparam int ECHO_MAX       = 30000;
  localparam int HOLDOFF_CYCLES = 80;
  localparam int WATCHDOG_LIMIT = 1000;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic              smp;
    logic [ECHO_W-1:0] echo;
  } echo_tick_t;

  typedef struct packed {
    lid_state_t         lid;
    logic [ANGLE_W-1:0] angle;
    logic               changed;
    logic               hand;
  } lid_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_sample_valid = 1'b0;
  logic [ECHO_W-1:0]    in_echo_us = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           out_lid_state;
  logic [ANGLE_W-1:0]   out_servo_angle;
  logic                 out_angle_changed;
  logic                 out_hand_seen;

  proximity_lid_servo_controller_core #(
    .TIMER_WIDTH(TMR_W)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample_valid  (in_sample_valid),
    .in_echo_us       (in_echo_us),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_lid_state    (out_lid_state),
    .out_servo_angle  (out_servo_angle),
    .out_angle_changed(out_angle_changed),
    .out_hand_seen    (out_hand_seen)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // lid model state and register copy
  lid_state_t         mdl_mode = LID_CLOSED;
  logic [ANGLE_W-1:0] mdl_angle = CLOSED_ANGLE_RST;
  logic [ECHO_W-1:0]  mdl_echo = '0;
  logic [TMR_W-1:0]   mdl_since_step = '1;
  logic [TMR_W-1:0]   mdl_since_hand = '0;
  logic [ECHO_W-1:0]  cfg_near = NEAR_ECHO_RST;
  logic [HOLD_W-1:0]  cfg_hold = HOLD_TICKS_RST;
  logic [STEP_W-1:0]  cfg_step = STEP_TICKS_RST;
  logic [ANGLE_W-1:0] cfg_open = OPEN_ANGLE_RST;
  logic [ANGLE_W-1:0] cfg_closed = CLOSED_ANGLE_RST;

  echo_tick_t  echo_ticks_pending[$];
  lid_result_t lid_results_due[$];
  echo_tick_t  next_tick;
  lid_result_t due_res;

  int unsigned ticks_queued = 0;
  int unsigned results_seen = 0;
  int unsigned fail_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned long_stall_reqs = 0;
  int unsigned long_stall_done = 0;
  int unsigned holdoff_cnt = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned free_left = 0;
  logic        in_taken = 1'b0;

  task automatic step_servo(input logic [ANGLE_W-1:0] goal, inout logic moved,
                            output logic reached);
    reached = 1'b0;
    if (mdl_since_step >= cfg_step) begin
      mdl_since_step = '0;
      if (mdl_angle < goal) begin
        mdl_angle = mdl_angle + 1'b1;
        moved = 1'b1;
      end else if (mdl_angle > goal) begin
        mdl_angle = mdl_angle - 1'b1;
        moved = 1'b1;
      end
      reached = (mdl_angle == goal);
    end
  endtask

  task automatic predict_lid_tick(input logic smp, input logic [ECHO_W-1:0] echo);
    lid_result_t res;
    logic        hand;
    logic        moved;
    logic        reached;
    moved = 1'b0;
    reached = 1'b0;
    if (smp) mdl_echo = echo;
    if (mdl_since_step != '1) mdl_since_step = mdl_since_step + 1'b1;
    if (mdl_since_hand != '1) mdl_since_hand = mdl_since_hand + 1'b1;
    hand = (mdl_echo != '0) && (mdl_echo <= cfg_near);
    case (mdl_mode)
      LID_CLOSED: begin
        if (hand) mdl_mode = LID_OPENING;
      end
      LID_OPENING: begin
        step_servo(cfg_open, moved, reached);
        if (reached) begin
          mdl_mode = LID_OPEN;
          mdl_since_hand = '0;
        end
      end
      LID_OPEN: begin
        if (hand) mdl_since_hand = '0;
        else if (mdl_since_hand >= cfg_hold) mdl_mode = LID_CLOSING;
      end
      LID_CLOSING: begin
        if (hand) begin
          mdl_mode = LID_OPENING;
        end else begin
          step_servo(cfg_closed, moved, reached);
          if (reached) mdl_mode = LID_CLOSED;
        end
      end
      default: ;
    endcase
    res.lid = mdl_mode;
    res.angle = mdl_angle;
    res.changed = moved;
    res.hand = hand;
    lid_results_due.push_back(res);
  endtask

  // input side: bursts of requests with random gaps
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (gap_left == 0 && echo_ticks_pending.size() != 0) begin
        next_tick = echo_ticks_pending.pop_front();
        in_valid <= 1'b1;
        in_sample_valid <= next_tick.smp;
        in_echo_us <= next_tick.echo;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
        in_sample_valid <= 1'($urandom_range(0, 1));
        in_echo_us <= ECHO_W'($urandom_range(0, ECHO_MAX));
        if (gap_left != 0) gap_left--;
      end
    end
  end

  // result side: own stall pattern plus long hold-off on request
  always @(negedge clk) begin
    if (long_stall_reqs != long_stall_done) begin
      out_stall <= 1'b1;
      if (holdoff_cnt == HOLDOFF_CYCLES - 1) begin
        holdoff_cnt = 0;
        long_stall_done++;
      end else begin
        holdoff_cnt++;
      end
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (free_left != 0) begin
      out_stall <= 1'b0;
      free_left--;
    end else begin
      out_stall <= 1'b0;
      stall_left = $urandom_range(0, 3);
      free_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
    end
  end

  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) predict_lid_tick(in_sample_valid, in_echo_us);
    if (rst_n && out_valid && !out_stall) begin
      if (lid_results_due.size() == 0) begin
        $error("result with no request outstanding");
        fail_count++;
      end else begin
        due_res = lid_results_due.pop_front();
        if (out_lid_state !== due_res.lid) begin
          $error("lid_state: expected %0d, actual %0d", due_res.lid, out_lid_state);
          fail_count++;
        end
        if (out_servo_angle !== due_res.angle) begin
          $error("servo_angle: expected %0d, actual %0d", due_res.angle, out_servo_angle);
          fail_count++;
        end
        if (out_angle_changed !== due_res.changed) begin
          $error("angle_changed: expected %0d, actual %0d", due_res.changed,
                 out_angle_changed);
          fail_count++;
        end
        if (out_hand_seen !== due_res.hand) begin
          $error("hand_seen: expected %0d, actual %0d", due_res.hand, out_hand_seen);
          fail_count++;
        end
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** proximity_lid_servo_controller_core: FAILED **");
      $finish;
    end
  end

  task automatic queue_tick(input logic smp, input logic [ECHO_W-1:0] echo);
    echo_tick_t t;
    t.smp = smp;
    t.echo = echo;
    echo_ticks_pending.push_back(t);
    ticks_queued++;
  endtask

  task automatic wait_drained();
    while (results_seen != ticks_queued) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_NEAR_ECHO:    cfg_near = val[ECHO_W-1:0];
      REG_HOLD_TICKS:   cfg_hold = val[HOLD_W-1:0];
      REG_STEP_TICKS:   cfg_step = val[STEP_W-1:0];
      REG_OPEN_ANGLE:   cfg_open = val[ANGLE_W-1:0];
      REG_CLOSED_ANGLE: cfg_closed = val[ANGLE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input int near_us, input int hold_n, input int step_n,
                              input int open_deg, input int closed_deg);
    write_reg(REG_NEAR_ECHO, CFG_W'(near_us));
    write_reg(REG_HOLD_TICKS, CFG_W'(hold_n));
    write_reg(REG_STEP_TICKS, CFG_W'(step_n));
    write_reg(REG_OPEN_ANGLE, CFG_W'(open_deg));
    write_reg(REG_CLOSED_ANGLE, CFG_W'(closed_deg));
  endtask

  function automatic logic [ECHO_W-1:0] near_echo_pick();
    return ECHO_W'($urandom_range(1, cfg_near));
  endfunction

  function automatic logic [ECHO_W-1:0] far_echo_pick();
    if (cfg_near >= ECHO_MAX || $urandom_range(0, 3) == 0) return '0;
    return ECHO_W'($urandom_range(cfg_near + 1, ECHO_MAX));
  endfunction

  // hand and no-hand runs sized to the lid travel, with some noise runs
  task automatic run_phase(input int n, input int near_us, input int hold_n, input int step_n,
                           input int open_deg, input int closed_deg, input bit holdoff);
    int made;
    int len;
    int kind;
    int span;
    int k;
    program_regs(near_us, hold_n, step_n, open_deg, closed_deg);
    span = (open_deg > closed_deg) ? open_deg - closed_deg : closed_deg - open_deg;
    made = 0;
    while (made < n) begin
      kind = $urandom_range(0, 9);
      if (kind < 4) len = $urandom_range(1, (step_n + 1) * (span + 2) + 4);
      else if (kind < 8) len = $urandom_range(1, hold_n + 2 * (step_n + 1) * (span + 2));
      else len = $urandom_range(1, 6);
      for (k = 0; k < len && made < n; k++) begin
        if (kind >= 8)
          queue_tick(1'($urandom_range(0, 1)), ECHO_W'($urandom_range(0, ECHO_MAX)));
        else if (k == 0 || $urandom_range(0, 2) == 0)
          queue_tick(1'b1, (kind < 4) ? near_echo_pick() : far_echo_pick());
        else
          queue_tick(1'b0, ECHO_W'($urandom_range(0, ECHO_MAX)));
        made++;
      end
    end
    if (holdoff) long_stall_reqs++;
    wait_drained();
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // default registers: threshold edges, then opening from a saturated step timer
    queue_tick(1'b0, 15'd12345);
    queue_tick(1'b1, 15'd0);
    queue_tick(1'b1, 15'd30000);
    queue_tick(1'b1, 15'd1167);
    queue_tick(1'b1, 15'd1166);
    queue_tick(1'b0, 15'd0);
    wait_drained();

    // zero step interval and zero hold, tightest threshold
    program_regs(1, 0, 0, 2, 0);
    for (int i = REG_SPARE_LO; i <= REG_SPARE_HI; i++)
      write_reg(CFG_IDX_W'(i), CFG_W'($urandom_range(0, 65535)));
    queue_tick(1'b1, 15'd2);
    queue_tick(1'b0, 15'd1);
    queue_tick(1'b0, 15'd0);
    queue_tick(1'b1, 15'd1);
    queue_tick(1'b0, 15'd32767);
    queue_tick(1'b1, 15'd0);
    queue_tick(1'b0, 15'd1);
    queue_tick(1'b0, 15'd1);
    wait_drained();

    // threshold at ECHO_MAX, longest hold and step interval
    program_regs(ECHO_MAX, 65535, 255, 180, 0);
    queue_tick(1'b1, 15'd30000);
    queue_tick(1'b1, 15'd29999);
    queue_tick(1'b0, 15'd0);
    wait_drained();

    program_regs(ECHO_MAX, 65535, 0, 1, 0);
    queue_tick(1'b0, 15'd0);
    queue_tick(1'b1, 15'd0);
    queue_tick(1'b1, 15'd5000);
    wait_drained();

    for (int p = 0; p < 6; p++)
      run_phase(55, ($urandom_range(0, 4) == 0) ? ECHO_MAX : $urandom_range(1, 4000),
                $urandom_range(0, 12), $urandom_range(0, 3), $urandom_range(0, 10),
                $urandom_range(0, 10), p == 2);

    // angles above 180, then open angle below closed angle
    run_phase(100, 2000, 4, 0, 186, 180, 1'b0);
    run_phase(120, 2000, 3, 0, 255, 250, 1'b0);
    run_phase(80, 2000, 3, 0, 244, 252, 1'b0);

    wait_drained();
    repeat (5) @(negedge clk);
    if (fail_count == 0 && lid_results_due.size() == 0)
      $display("** proximity_lid_servo_controller_core: PASSED **");
    else
      $display("** proximity_lid_servo_controller_core: FAILED **");
    $finish;
  end

endmodule
